[src/two_finger_pinch_recognizer_unit_defines.svh]
// Assertion helpers used by the pinch recognizer unit.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TWO_FINGER_PINCH_RECOGNIZER_UNIT_DEFINES_SVH
`define TWO_FINGER_PINCH_RECOGNIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define TFPR_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define TFPR_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[src/tfpr_pkg.sv]
package tfpr_pkg;

	localparam int POS_W      = 16;
	localparam int TIME_W     = 32;
	localparam int COUNT_W    = 4;
	localparam int STATUS_W   = 2;
	localparam int GPH_W      = 2;
	localparam int SCALE_W    = 16;
	localparam int SPEED_W    = 20;
	localparam int CENTER_W   = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WCOUNT_W   = 8;
	localparam int FRAMES_W   = 8;

	typedef enum logic [1:0] {
		PH_CLEAR,
		PH_POSSIBLE,
		PH_STARTED
	} phase_t;

	typedef enum logic [GPH_W-1:0] {
		G_STARTED,
		G_CONTINUING,
		G_FINISHED,
		G_CANCELLED
	} gesture_t;

	localparam logic [STATUS_W-1:0] ST_UP          = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INTERRUPTED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE_DELTA    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES_TO_START   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES_PER_UPDATE = 2'd2;

	localparam logic [15:0]         MDD_RESET = 16'd160;
	localparam logic [FRAMES_W-1:0] MFS_RESET = 8'd4;
	localparam logic [FRAMES_W-1:0] MFU_RESET = 8'd4;

	localparam logic [SCALE_W-1:0]  SCALE_MAX = 16'hFFFF;
	localparam logic [SPEED_W-1:0]  SPEED_MAX = 20'hFFFFF;
	localparam logic [WCOUNT_W-1:0] WC_MAX    = 8'hFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_D1,
		S_D1W,
		S_D2,
		S_D2W,
		S_TEST,
		S_SCALE,
		S_SCALEW,
		S_SPEED,
		S_SPEEDW,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_SQX,
		DS_SQY,
		DS_ROOT
	} dist_state_t;

endpackage

[src/tfpr_dist.sv]
module tfpr_dist #(
	parameter int CB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CB-1:0] ax,
	input  logic [CB-1:0] ay,
	input  logic [CB-1:0] bx,
	input  logic [CB-1:0] by,
	output logic          done,
	output logic [CB:0]   len
);
	import tfpr_pkg::*;

	localparam int SW = 2 * CB + 1;
	localparam int RW = 2 * CB + 2;
	localparam int MW = CB + 4;
	localparam int CW = $clog2(CB + 2);

	dist_state_t st_q, st_d;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [SW-1:0] acc_q, mcand_q, acc_nx;
	logic [CB-1:0] mplier_q, dy_q, dx_c, dy_c;
	logic [RW-1:0] rad_q;
	logic [MW-1:0] rem_q, remn, trial;
	logic [CB:0]   root_q;
	logic          ge, sq_last, root_last;

	assign dx_c      = (ax > bx) ? ax - bx : bx - ax;
	assign dy_c      = (ay > by) ? ay - by : by - ay;
	assign acc_nx    = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign remn      = {rem_q[MW-3:0], rad_q[RW-1:RW-2]};
	assign trial     = MW'({root_q, 2'b01});
	assign ge        = remn >= trial;
	assign sq_last   = cnt_q == CW'(CB - 1);
	assign root_last = cnt_q == CW'(CB);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			DS_IDLE: if (start) st_d = DS_SQX;
			DS_SQX:  if (sq_last) st_d = DS_SQY;
			DS_SQY:  if (sq_last) st_d = DS_ROOT;
			DS_ROOT: if (root_last) st_d = DS_IDLE;
			default: st_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DS_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == DS_ROOT) && root_last;
			if (st_d != st_q) cnt_q <= '0;
			else if (st_q != DS_IDLE) cnt_q <= cnt_q + CW'(1);
		end
	end

	// Squares by shift and add, one multiplier bit a cycle, then the root
	// one result bit a cycle.
	always_ff @(posedge clk) begin
		unique case (st_q)
			DS_IDLE: begin
				if (start) begin
					acc_q    <= '0;
					mcand_q  <= SW'(dx_c);
					mplier_q <= dx_c;
					dy_q     <= dy_c;
				end
			end
			DS_SQX, DS_SQY: begin
				acc_q <= acc_nx;
				if (sq_last && st_q == DS_SQX) begin
					mcand_q  <= SW'(dy_q);
					mplier_q <= dy_q;
				end else begin
					mcand_q  <= {mcand_q[SW-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[CB-1:1]};
				end
				if (sq_last && st_q == DS_SQY) begin
					rad_q  <= {1'b0, acc_nx};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			DS_ROOT: begin
				rem_q  <= ge ? remn - trial : remn;
				root_q <= {root_q[CB-1:0], ge};
				rad_q  <= {rad_q[RW-3:0], 2'b00};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign len  = root_q;

endmodule

[src/tfpr_div.sv]
module tfpr_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q, done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q, quot_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [DEN_W:0]   remn, diff;
	logic             ge;

	assign remn = {rem_q, num_q[NUM_W-1]};
	assign diff = remn - {1'b0, den_q};
	assign ge   = remn >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit a cycle.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : remn[DEN_W-1:0];
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[src/two_finger_pinch_recognizer_unit.sv]
// Two-finger pinch recognizer. One touch frame enters on the input channel
// (in_valid/in_ready) and causes zero or one result item on the output channel
// (out_valid/out_ready). Registers are written through the cfg channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is always high and an
// index beyond the register list is ignored. Write registers only while idle.
// Each frame is handled on its own: in_ready is high only in the idle state.
// A frame that only updates the window passes through the decide state back
// to idle; a cancelled result goes from the decide state to the output stage.
// Each distance runs bit-serially (squares by shift and add, then the root one
// bit a cycle), and the scale and the speed each take a pass through the shared
// restoring divider. A window that fails the start test returns to idle after
// the test. A result leaves through the output stage, and the next frame can
// be accepted in the cycle after the result is loaded into the output register;
// a division by a zero starting distance or a zero elapsed time is skipped.
// The result sits in an output register; a new result is held back until the
// receiver has taken the old one, so a stalled receiver simply delays the block.
// Reset puts the recognizer in the clear phase with an empty window and the
// registers at their defaults (160, 4, 4); no clearing pass is needed.
`include "two_finger_pinch_recognizer_unit_defines.svh"
module two_finger_pinch_recognizer_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tfpr_pkg::COUNT_W-1:0]      point_count,
	input  logic [tfpr_pkg::POS_W-1:0]        first_x,
	input  logic [tfpr_pkg::POS_W-1:0]        first_y,
	input  logic [tfpr_pkg::STATUS_W-1:0]     first_status,
	input  logic [tfpr_pkg::POS_W-1:0]        second_x,
	input  logic [tfpr_pkg::POS_W-1:0]        second_y,
	input  logic [tfpr_pkg::STATUS_W-1:0]     second_status,
	input  logic [tfpr_pkg::TIME_W-1:0]       frame_time,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tfpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tfpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tfpr_pkg::GPH_W-1:0]        gesture_phase,
	output logic [tfpr_pkg::SCALE_W-1:0]      scale,
	output logic [tfpr_pkg::SPEED_W-1:0]      speed,
	output logic [tfpr_pkg::CENTER_W-1:0]     center_x,
	output logic [tfpr_pkg::CENTER_W-1:0]     center_y,
	output logic [tfpr_pkg::TIME_W-1:0]       event_time
);
	import tfpr_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int DW    = CB + 1;
	localparam int NUM_W = CB + 9;
	localparam int DEN_W = TIME_W + 1;

	// Control and window state.
	ctrl_state_t           state_q, state_d;
	phase_t                phase_q;
	logic [WCOUNT_W-1:0]   wc_q, pushed_wc;
	logic [CB-1:0]         first_q [4];
	logic [CB-1:0]         last_q [4];
	logic [TIME_W-1:0]     ft_q;
	logic [DW-1:0]         sd_q;
	logic [15:0]           mdd_q;
	logic [FRAMES_W-1:0]   mfs_q, mfu_q;
	gesture_t              kind_q;
	logic                  cancel_q, test_q;
	logic                  out_valid_q;

	// Latched frame and working values.
	logic [COUNT_W-1:0]    cnt_in_q;
	logic [STATUS_W-1:0]   s1_q, s2_q;
	logic [CB-1:0]         cur_q [4];
	logic [TIME_W-1:0]     t_q;
	logic [DW-1:0]         d1_q, d2_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [SPEED_W-1:0]    speed_q;

	// Output register.
	gesture_t              gesture_phase_q;
	logic [SCALE_W-1:0]    scale_out_q;
	logic [SPEED_W-1:0]    speed_out_q;
	logic [CENTER_W-1:0]   center_x_q, center_y_q;
	logic [TIME_W-1:0]     event_time_q;

	// Decisions taken when a frame is examined.
	logic                  dec_push, dec_phase_we, dec_wc_clr, dec_cancel, dec_test;
	phase_t                dec_phase_nx;
	gesture_t              dec_kind;

	logic                  in_fire, out_load;
	logic                  count_two, s1_up, s2_up, s1_int;
	logic [DW-1:0]         delta;
	logic                  start_ok;
	logic [TIME_W-1:0]     dt;
	logic [DW-1:0]         center_x_sum, center_y_sum;

	logic                  dist_start, dist_done, dist_sel_last;
	logic [CB-1:0]         dist_ax, dist_ay, dist_bx, dist_by;
	logic [DW-1:0]         dist_res;
	logic                  div_start, div_done;
	logic [NUM_W-1:0]      div_num, div_quot, speed_num;
	logic [DEN_W-1:0]      div_den;

	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign count_two = cnt_in_q == COUNT_W'(2);
	assign s1_up     = s1_q == ST_UP;
	assign s2_up     = s2_q == ST_UP;
	assign s1_int    = s1_q == ST_INTERRUPTED;
	assign pushed_wc = (wc_q == WC_MAX) ? wc_q : wc_q + WCOUNT_W'(1);

	assign delta    = (d1_q > d2_q) ? d1_q - d2_q : d2_q - d1_q;
	assign start_ok = 32'(delta) > 32'(mdd_q);
	assign dt       = t_q - ft_q;

	// Midpoint in Q12.5 is the plain sum of the two Q12.4 coordinates.
	assign center_x_sum = {1'b0, last_q[0]} + {1'b0, last_q[2]};
	assign center_y_sum = {1'b0, last_q[1]} + {1'b0, last_q[3]};

	// The first distance is taken from the window's first frame, the second
	// from its last frame, which equals the current frame whenever it was
	// pushed and holds the previous frame when a count change finishes.
	assign dist_sel_last = state_q == S_D2;
	assign dist_start    = (state_q == S_D1) || (state_q == S_D2);
	assign dist_ax = dist_sel_last ? last_q[0] : first_q[0];
	assign dist_ay = dist_sel_last ? last_q[1] : first_q[1];
	assign dist_bx = dist_sel_last ? last_q[2] : first_q[2];
	assign dist_by = dist_sel_last ? last_q[3] : first_q[3];

	// Speed is delta * 1000 / (dt * 16) in Q12.4 units, that is
	// delta * 125 / (dt * 2); the times 125 is done by shifts, a subtraction and an addition.
	assign speed_num = NUM_W'({delta, 7'b0}) - NUM_W'({delta, 2'b0}) + NUM_W'(delta);
	assign div_start = ((state_q == S_SCALE) && (sd_q != '0)) ||
		((state_q == S_SPEED) && (dt != '0));
	assign div_num   = (state_q == S_SCALE) ? {d2_q, 8'b0} : speed_num;
	assign div_den   = (state_q == S_SCALE) ? DEN_W'(sd_q) : {dt, 1'b0};

	tfpr_dist #(
		.CB(CB)
	) u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dist_start),
		.ax    (dist_ax),
		.ay    (dist_ay),
		.bx    (dist_bx),
		.by    (dist_by),
		.done  (dist_done),
		.len   (dist_res)
	);

	tfpr_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		dec_push     = 1'b0;
		dec_phase_we = 1'b0;
		dec_phase_nx = PH_CLEAR;
		dec_wc_clr   = 1'b0;
		dec_cancel   = 1'b0;
		dec_test     = 1'b0;
		dec_kind     = G_FINISHED;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = S_IDLE;
				unique case (phase_q)
					PH_CLEAR: begin
						// The window is always empty here, so the push opens it.
						if (count_two) begin
							dec_push     = 1'b1;
							dec_phase_we = 1'b1;
							dec_phase_nx = PH_POSSIBLE;
						end
					end
					PH_POSSIBLE: begin
						if (!count_two || s1_up || s2_up || s1_int) begin
							dec_phase_we = 1'b1;
							dec_wc_clr   = 1'b1;
						end else if (mfs_q == '0) begin
							// A zero frame threshold never starts a pinch.
							dec_push     = 1'b1;
							dec_phase_we = 1'b1;
							dec_wc_clr   = 1'b1;
						end else begin
							dec_push = 1'b1;
							if (pushed_wc >= mfs_q) begin
								dec_test = 1'b1;
								state_d  = S_D1;
							end
						end
					end
					PH_STARTED: begin
						priority if (s1_int) begin
							dec_cancel   = 1'b1;
							dec_phase_we = 1'b1;
							dec_wc_clr   = 1'b1;
							state_d      = S_OUT;
						end else if (!count_two) begin
							dec_phase_we = 1'b1;
							dec_wc_clr   = 1'b1;
							// An empty window gives a cancelled result with no values.
							if (wc_q == '0) begin
								dec_cancel = 1'b1;
								state_d    = S_OUT;
							end else begin
								state_d = S_D1;
							end
						end else if (s1_up || s2_up) begin
							dec_push     = 1'b1;
							dec_phase_we = 1'b1;
							dec_wc_clr   = 1'b1;
							state_d      = S_D1;
						end else begin
							dec_push = 1'b1;
							if (pushed_wc >= mfu_q) begin
								dec_wc_clr = 1'b1;
								dec_kind   = G_CONTINUING;
								state_d    = S_D1;
							end
						end
					end
					default: begin
						dec_phase_we = 1'b1;
						dec_wc_clr   = 1'b1;
					end
				endcase
			end
			S_D1:     state_d = S_D1W;
			S_D1W:    if (dist_done) state_d = S_D2;
			S_D2:     state_d = S_D2W;
			S_D2W:    if (dist_done) state_d = test_q ? S_TEST : S_SCALE;
			S_TEST:   state_d = start_ok ? S_SCALE : S_IDLE;
			S_SCALE:  state_d = (sd_q == '0) ? S_SPEED : S_SCALEW;
			S_SCALEW: if (div_done) state_d = S_SPEED;
			S_SPEED:  state_d = (dt == '0) ? S_OUT : S_SPEEDW;
			S_SPEEDW: if (div_done) state_d = S_OUT;
			S_OUT:    if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CLEAR;
			wc_q        <= '0;
			ft_q        <= '0;
			sd_q        <= '0;
			mdd_q       <= MDD_RESET;
			mfs_q       <= MFS_RESET;
			mfu_q       <= MFU_RESET;
			kind_q      <= G_FINISHED;
			cancel_q    <= 1'b0;
			test_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				first_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_DISTANCE_DELTA:    mdd_q <= cfg_data;
					CFG_MIN_FRAMES_TO_START:   mfs_q <= cfg_data[FRAMES_W-1:0];
					CFG_MIN_FRAMES_PER_UPDATE: mfu_q <= cfg_data[FRAMES_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_DECIDE) begin
				if (dec_push) begin
					if (wc_q == '0) begin
						first_q <= cur_q;
						ft_q    <= t_q;
					end
					last_q <= cur_q;
				end
				if (dec_phase_we) phase_q <= dec_phase_nx;
				if (dec_wc_clr) wc_q <= '0;
				else if (dec_push) wc_q <= pushed_wc;
				kind_q   <= dec_kind;
				cancel_q <= dec_cancel;
				test_q   <= dec_test;
			end

			if (state_q == S_TEST) begin
				wc_q <= '0;
				if (start_ok) begin
					phase_q <= PH_STARTED;
					kind_q  <= G_STARTED;
					// With a one-frame window the window restarts at this frame.
					if (mfs_q == FRAMES_W'(1)) begin
						first_q <= last_q;
						ft_q    <= t_q;
						sd_q    <= d2_q;
					end else begin
						sd_q <= d1_q;
					end
				end else begin
					phase_q <= PH_CLEAR;
				end
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cnt_in_q <= point_count;
			s1_q     <= first_status;
			s2_q     <= second_status;
			cur_q[0] <= CB'(first_x);
			cur_q[1] <= CB'(first_y);
			cur_q[2] <= CB'(second_x);
			cur_q[3] <= CB'(second_y);
			t_q      <= frame_time;
		end
		if (state_q == S_D1W && dist_done) d1_q <= dist_res;
		if (state_q == S_D2W && dist_done) d2_q <= dist_res;
		if (state_q == S_TEST && mfs_q == FRAMES_W'(1)) d1_q <= d2_q;

		if (state_q == S_SCALE && sd_q == '0) begin
			scale_q <= (d2_q != '0) ? SCALE_MAX : '0;
		end
		if (state_q == S_SCALEW && div_done) begin
			scale_q <= (div_quot > NUM_W'(SCALE_MAX)) ? SCALE_MAX : SCALE_W'(div_quot);
		end
		if (state_q == S_SPEED && dt == '0) begin
			speed_q <= (delta != '0) ? SPEED_MAX : '0;
		end
		if (state_q == S_SPEEDW && div_done) begin
			speed_q <= (div_quot > NUM_W'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(div_quot);
		end

		if (out_load) begin
			event_time_q <= t_q;
			if (cancel_q) begin
				gesture_phase_q <= G_CANCELLED;
				scale_out_q     <= '0;
				speed_out_q     <= '0;
				center_x_q      <= '0;
				center_y_q      <= '0;
			end else begin
				gesture_phase_q <= kind_q;
				scale_out_q     <= scale_q;
				speed_out_q     <= speed_q;
				center_x_q      <= CENTER_W'(center_x_sum);
				center_y_q      <= CENTER_W'(center_y_sum);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign gesture_phase = gesture_phase_q;
	assign scale         = scale_out_q;
	assign speed         = speed_out_q;
	assign center_x      = center_x_q;
	assign center_y      = center_y_q;
	assign event_time    = event_time_q;

	`TFPR_CHECK(a_out_no_overwrite, out_load, !out_valid_q || out_ready, "result overwritten")
	`TFPR_CHECK(a_dist_done_waits, dist_done, state_q == S_D1W || state_q == S_D2W, "stray distance")
	`TFPR_CHECK(a_div_done_waits, div_done, state_q == S_SCALEW || state_q == S_SPEEDW, "stray quotient")
	`TFPR_CHECK_NEXT(a_phase_idle_hold, state_q == S_IDLE && !in_valid, $stable(phase_q), "phase moved")

endmodule
